### hdl/timestamp_sync_interpolator_defines.svh
// Assertion helpers, clocked on clk and disabled during reset
`ifndef TIMESTAMP_SYNC_INTERPOLATOR_DEFINES_SVH
`define TIMESTAMP_SYNC_INTERPOLATOR_DEFINES_SVH

// condition must hold on every edge out of reset
`define TSI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tsi_pkg.sv
`default_nettype none
package tsi_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int WEIGHT_BITS = 16;
	localparam int W_W = WEIGHT_BITS + 1;
	localparam int DIV_STEPS = WEIGHT_BITS + 1;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int NUM_FIELDS = 6;
	localparam int FLD_W = $clog2(NUM_FIELDS);
	localparam int VAL_W = 40;
	localparam int PROD_W = VAL_W + W_W + 1;
	localparam logic [19:0] GAP_RESET = 20'd10000;

	typedef enum logic [1:0] {
		OC_SYNCED = 2'd0,
		OC_FEW    = 2'd1,
		OC_EARLY  = 2'd2,
		OC_GAP    = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOP, ST_RD_F, ST_RD_B, ST_CAP, ST_EVAL,
		ST_DIV, ST_MUL, ST_ACC, ST_RESULT
	} state_t;

	typedef struct packed {
		logic [47:0]        stamp;
		logic [7:0]         status;
		logic signed [37:0] lat;
		logic signed [38:0] lon;
		logic signed [27:0] alt;
		logic signed [31:0] east;
		logic signed [31:0] north;
		logic signed [31:0] up;
	} entry_t;

	typedef struct packed {
		logic             latch;
		logic             push;
		logic             pop;
		logic             rd_back;
		logic             cap_front;
		logic             cap_back;
		logic             div_init;
		logic             div_step;
		logic             div_first;
		logic             mul;
		logic             acc;
		logic [FLD_W-1:0] fld;
		logic             set_code;
		outcome_t         code;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic fill_lt2;
		logic f_gt_t;
		logic b_lt_t;
		logic gap_bad;
		logic out_busy;
	} stat_t;

	// index sum with wrap at the queue depth
	function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [FILL_W-1:0] b);
		logic [FILL_W:0] s;
		s = {{(FILL_W+1-IDX_W){1'b0}}, a} + {1'b0, b};
		if (s >= (FILL_W+1)'(QUEUE_DEPTH))
			s = s - (FILL_W+1)'(QUEUE_DEPTH);
		return s[IDX_W-1:0];
	endfunction

	// position field k of an entry, sign extended
	function automatic logic signed [VAL_W-1:0] field_val(entry_t e, logic [FLD_W-1:0] k);
		logic signed [VAL_W-1:0] v;
		unique case (k)
			3'd0: v = VAL_W'(e.lat);
			3'd1: v = VAL_W'(e.lon);
			3'd2: v = VAL_W'(e.alt);
			3'd3: v = VAL_W'(e.east);
			3'd4: v = VAL_W'(e.north);
			default: v = VAL_W'(e.up);
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/tsi_dp.sv
`default_nettype none
module tsi_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tsi_pkg::cmd_t       cmd,
	output tsi_pkg::stat_t           stat,
	input  wire logic                cfg_we,
	input  wire logic [19:0]         cfg_wdata,
	input  wire logic [47:0]         stamp,
	input  wire logic [7:0]          fix_status,
	input  wire logic signed [37:0]  lat_nanodeg,
	input  wire logic signed [38:0]  lon_nanodeg,
	input  wire logic signed [27:0]  alt_mm,
	input  wire logic signed [31:0]  east_mm,
	input  wire logic signed [31:0]  north_mm,
	input  wire logic signed [31:0]  up_mm,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               outcome,
	output logic [47:0]              out_stamp,
	output logic [7:0]               out_status,
	output logic signed [37:0]       out_lat,
	output logic signed [38:0]       out_lon,
	output logic signed [27:0]       out_alt,
	output logic signed [31:0]       out_east,
	output logic signed [31:0]       out_north,
	output logic signed [31:0]       out_up
);
	`include "timestamp_sync_interpolator_defines.svh"

	tsi_pkg::entry_t mem [tsi_pkg::QUEUE_DEPTH];
	tsi_pkg::entry_t rd_q, front_q, back_q, wr_entry;
	logic [tsi_pkg::IDX_W-1:0]  head_q, wr_addr, rd_addr;
	logic [tsi_pkg::FILL_W-1:0] fill_q;
	logic [19:0]  max_gap_q;
	logic [47:0]  t_q, span_q;
	logic [48:0]  rem_q, shifted;
	logic [tsi_pkg::W_W-1:0] quo_q, w;
	tsi_pkg::outcome_t code_q;
	logic signed [tsi_pkg::PROD_W-1:0] prod_s1;
	logic signed [tsi_pkg::VAL_W-1:0]  res_q [tsi_pkg::NUM_FIELDS];
	logic signed [tsi_pkg::VAL_W-1:0]  fa, fb, diff;
	logic signed [tsi_pkg::PROD_W-1:0] rnd;
	logic full, out_valid_q, ok;

	// queue write slot and read address
	assign full = (fill_q == tsi_pkg::FILL_W'(tsi_pkg::QUEUE_DEPTH));
	assign wr_addr = full ? head_q : tsi_pkg::wrap_add(head_q, fill_q);
	assign rd_addr = cmd.rd_back ? tsi_pkg::wrap_add(head_q, tsi_pkg::FILL_W'(1)) : head_q;
	assign wr_entry = '{stamp: stamp, status: fix_status, lat: lat_nanodeg,
		lon: lon_nanodeg, alt: alt_mm, east: east_mm, north: north_mm, up: up_mm};

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wr_addr] <= wr_entry;
		rd_q <= mem[rd_addr];
	end

	// head pointer, fill count, config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			max_gap_q <= tsi_pkg::GAP_RESET;
		end else begin
			if (cfg_we)
				max_gap_q <= cfg_wdata;
			if (cmd.push) begin
				if (full)
					head_q <= tsi_pkg::wrap_add(head_q, tsi_pkg::FILL_W'(1));
				else
					fill_q <= fill_q + 1'b1;
			end else if (cmd.pop) begin
				head_q <= tsi_pkg::wrap_add(head_q, tsi_pkg::FILL_W'(1));
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// queue fill check, bracket checks on the captured neighbors, output busy
	assign stat.fill_lt2 = (fill_q < tsi_pkg::FILL_W'(2));
	assign stat.f_gt_t   = (front_q.stamp > t_q);
	assign stat.b_lt_t   = (back_q.stamp < t_q);
	assign stat.gap_bad  = ((t_q - front_q.stamp) > {28'd0, max_gap_q}) ||
		((back_q.stamp - t_q) > {28'd0, max_gap_q});
	assign stat.out_busy = out_valid_q && !out_ready;

	// restoring divider: weight = ((t - f) << WEIGHT_BITS) / span
	assign shifted = cmd.div_first ? rem_q : {rem_q[47:0], 1'b0};
	assign ok = (shifted >= {1'b0, span_q});
	assign w = (span_q == '0) ? '0 : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.latch)
			t_q <= stamp;
		if (cmd.cap_front)
			front_q <= rd_q;
		if (cmd.cap_back)
			back_q <= rd_q;
		if (cmd.set_code)
			code_q <= cmd.code;
		if (cmd.div_init) begin
			rem_q <= {1'b0, t_q - front_q.stamp};
			span_q <= back_q.stamp - front_q.stamp;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ok ? shifted - {1'b0, span_q} : shifted;
			quo_q <= {quo_q[tsi_pkg::W_W-2:0], ok};
		end
	end

	// shared multiplier, one field per pass: a + round((b - a) * w / 2^WB)
	assign fa = tsi_pkg::field_val(front_q, cmd.fld);
	assign fb = tsi_pkg::field_val(back_q, cmd.fld);
	assign diff = fb - fa;
	assign rnd = prod_s1 + tsi_pkg::PROD_W'(1 << (tsi_pkg::WEIGHT_BITS - 1));

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_s1 <= tsi_pkg::PROD_W'(diff) * $signed({1'b0, w});
		if (cmd.acc)
			res_q[cmd.fld] <= fa + tsi_pkg::VAL_W'(rnd >>> tsi_pkg::WEIGHT_BITS);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			outcome <= code_q;
			out_stamp <= t_q;
			if (code_q == tsi_pkg::OC_SYNCED) begin
				out_status <= back_q.status;
				out_lat   <= res_q[0][37:0];
				out_lon   <= res_q[1][38:0];
				out_alt   <= res_q[2][27:0];
				out_east  <= res_q[3][31:0];
				out_north <= res_q[4][31:0];
				out_up    <= res_q[5][31:0];
			end else begin
				out_status <= '0;
				out_lat <= '0;
				out_lon <= '0;
				out_alt <= '0;
				out_east <= '0;
				out_north <= '0;
				out_up <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`TSI_ASSERT_ALWAYS(a_fill_bound, fill_q <= tsi_pkg::FILL_W'(tsi_pkg::QUEUE_DEPTH), "fill over depth")
	`TSI_ASSERT_IMPL(a_pop_two, cmd.pop, fill_q >= tsi_pkg::FILL_W'(2), "pop with short queue")
	`TSI_ASSERT_IMPL(a_load_free, cmd.out_load, !(out_valid_q && !out_ready), "result overwritten")
	`TSI_ASSERT_NEXT(a_pop_shrinks, cmd.pop && !cmd.push, fill_q == $past(fill_q) - 1'b1, "pop lost")
endmodule
`default_nettype wire

### hdl/tsi_ctrl.sv
`default_nettype none
module tsi_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          action,
	input  wire tsi_pkg::stat_t stat,
	output tsi_pkg::cmd_t      cmd
);
	tsi_pkg::state_t state_q, state_d;
	logic [tsi_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
	logic [tsi_pkg::FLD_W-1:0]  fld_q, fld_d;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsi_pkg::ST_IDLE;
			dcnt_q <= '0;
			fld_q <= '0;
		end else begin
			state_q <= state_d;
			dcnt_q <= dcnt_d;
			fld_q <= fld_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		dcnt_d = dcnt_q;
		fld_d = fld_q;
		cmd = '0;
		cmd.code = tsi_pkg::OC_SYNCED;
		cmd.fld = fld_q;
		in_ready = 1'b0;
		unique case (state_q)
			tsi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!action) begin
						cmd.push = 1'b1;
					end else begin
						cmd.latch = 1'b1;
						state_d = tsi_pkg::ST_LOOP;
					end
				end
			end
			tsi_pkg::ST_LOOP: begin
				if (stat.fill_lt2) begin
					cmd.set_code = 1'b1;
					cmd.code = tsi_pkg::OC_FEW;
					state_d = tsi_pkg::ST_RESULT;
				end else begin
					state_d = tsi_pkg::ST_RD_F;
				end
			end
			tsi_pkg::ST_RD_F: state_d = tsi_pkg::ST_RD_B;
			tsi_pkg::ST_RD_B: begin
				cmd.cap_front = 1'b1;
				cmd.rd_back = 1'b1;
				state_d = tsi_pkg::ST_CAP;
			end
			tsi_pkg::ST_CAP: begin
				cmd.cap_back = 1'b1;
				state_d = tsi_pkg::ST_EVAL;
			end
			tsi_pkg::ST_EVAL: begin
				priority if (stat.f_gt_t) begin
					cmd.set_code = 1'b1;
					cmd.code = tsi_pkg::OC_EARLY;
					state_d = tsi_pkg::ST_RESULT;
				end else if (stat.b_lt_t) begin
					cmd.pop = 1'b1;
					state_d = tsi_pkg::ST_LOOP;
				end else if (stat.gap_bad) begin
					cmd.pop = 1'b1;
					cmd.set_code = 1'b1;
					cmd.code = tsi_pkg::OC_GAP;
					state_d = tsi_pkg::ST_RESULT;
				end else begin
					cmd.div_init = 1'b1;
					dcnt_d = '0;
					state_d = tsi_pkg::ST_DIV;
				end
			end
			tsi_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_first = (dcnt_q == '0);
				dcnt_d = dcnt_q + 1'b1;
				if (dcnt_q == tsi_pkg::DCNT_W'(tsi_pkg::DIV_STEPS - 1)) begin
					fld_d = '0;
					state_d = tsi_pkg::ST_MUL;
				end
			end
			tsi_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = tsi_pkg::ST_ACC;
			end
			tsi_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				if (fld_q == tsi_pkg::FLD_W'(tsi_pkg::NUM_FIELDS - 1)) begin
					cmd.set_code = 1'b1;
					cmd.code = tsi_pkg::OC_SYNCED;
					state_d = tsi_pkg::ST_RESULT;
				end else begin
					fld_d = fld_q + 1'b1;
					state_d = tsi_pkg::ST_MUL;
				end
			end
			tsi_pkg::ST_RESULT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = tsi_pkg::ST_IDLE;
				end
			end
			default: state_d = tsi_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### hdl/timestamp_sync_interpolator.sv
`default_nettype none
// Timestamp sync interpolator. A push beat (action 0) stores a position sample
// in a 16-entry queue, overwriting the oldest when full. A sync beat (action 1)
// yields one result beat. Each bracket check runs the loop test, two reads from
// the queue memory, capture and compare, and runs once per stale sample popped
// plus once more; a failed check then loads the result, and when fewer than two
// samples remain the loop test ends the sync. A successful sync then runs the
// serial weight divider and the shared multiplier (multiply, then round and
// accumulate, for each field) before the result is loaded. The input is taken
// again only after the result is placed in the output register, which holds it
// until out_ready.
module timestamp_sync_interpolator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [19:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [47:0]        stamp,
	input  wire logic [7:0]         fix_status,
	input  wire logic signed [37:0] lat_nanodeg,
	input  wire logic signed [38:0] lon_nanodeg,
	input  wire logic signed [27:0] alt_mm,
	input  wire logic signed [31:0] east_mm,
	input  wire logic signed [31:0] north_mm,
	input  wire logic signed [31:0] up_mm,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              outcome,
	output logic [47:0]             out_stamp,
	output logic [7:0]              out_status,
	output logic signed [37:0]      out_lat,
	output logic signed [38:0]      out_lon,
	output logic signed [27:0]      out_alt,
	output logic signed [31:0]      out_east,
	output logic signed [31:0]      out_north,
	output logic signed [31:0]      out_up
);
	tsi_pkg::cmd_t  cmd;
	tsi_pkg::stat_t stat;

	// sequencer
	tsi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .stat(stat), .cmd(cmd)
	);

	// queue, divider, multiplier and output register
	tsi_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.stamp(stamp), .fix_status(fix_status), .lat_nanodeg(lat_nanodeg),
		.lon_nanodeg(lon_nanodeg), .alt_mm(alt_mm), .east_mm(east_mm),
		.north_mm(north_mm), .up_mm(up_mm),
		.out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
		.out_stamp(out_stamp), .out_status(out_status), .out_lat(out_lat),
		.out_lon(out_lon), .out_alt(out_alt), .out_east(out_east),
		.out_north(out_north), .out_up(out_up)
	);
endmodule
`default_nettype wire
